### rtl/ttms_pkg.sv
// shared types, constants and helpers for the tournament tree merge selector
`default_nettype none

package ttms_pkg;

    // tree shape
    localparam int LEAVES   = 8;
    localparam int KEY_BITS = 64;

    // fixed field widths of the request and result beats
    localparam int IDX_BITS   = 3;
    localparam int FKEY_BITS  = 64;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // padded leaf count: next power of two at or above LEAVES (up to 512), at least two
    function automatic int calc_span();
        int s;
        s = 2;
        for (int i = 0; i < 8; i++) begin
            if (s < LEAVES) begin
                s = s * 2;
            end
        end
        return s;
    endfunction

    localparam int SPAN   = calc_span();
    localparam int LEVELS = $clog2(SPAN);
    localparam int LEAF_W = LEVELS;
    localparam int NODE_W = LEVELS + 1;
    localparam int NODES  = 2 * SPAN;

    // ghost payload (key and leaf reported when no winner exists)
    localparam logic [KEY_BITS-1:0] NO_WINNER_KEY = '0;

    // one tree node: winner mark, winning leaf and its key
    typedef struct packed {
        logic                vld;
        logic [LEAF_W-1:0]   leaf;
        logic [KEY_BITS-1:0] key;
    } t_node;

    // write request into the node store
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_node             node;
    } t_node_wr;

endpackage

`default_nettype wire

### rtl/ttms_ifs.sv
// request and result channel interfaces
`default_nettype none

// request channel: insert or pop with refill
interface ttms_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [ttms_pkg::IDX_BITS-1:0]   leaf_index;
    logic [ttms_pkg::FKEY_BITS-1:0]  key;
    logic                            refill_valid;

    modport source (output valid, req_type, leaf_index, key, refill_valid, input ready);
    modport sink   (input valid, req_type, leaf_index, key, refill_valid, output ready);
endinterface

// result channel: winner report
interface ttms_res_if;
    logic                            valid;
    logic                            ready;
    logic                            winner_valid;
    logic [ttms_pkg::IDX_BITS-1:0]   winner_leaf;
    logic [ttms_pkg::FKEY_BITS-1:0]  winner_key;
    logic                            more_pending;

    modport source (output valid, winner_valid, winner_leaf, winner_key, more_pending,
                    input ready);
    modport sink   (input valid, winner_valid, winner_leaf, winner_key, more_pending,
                    output ready);
endinterface

`default_nettype wire

### rtl/ttms_node_store.sv
// tree node storage: winner mark, leaf and key per node, one sibling read port, one root read port and one write port
`default_nettype none

module ttms_node_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ttms_pkg::NODE_W-1:0]   i_rd_addr,
    input  wire ttms_pkg::t_node_wr            i_wr,
    output ttms_pkg::t_node                    o_rd_node,
    output ttms_pkg::t_node                    o_root
);

    logic [ttms_pkg::NODES-1:0]    r_vld;
    logic [ttms_pkg::LEAF_W-1:0]   r_leaf [ttms_pkg::NODES];
    logic [ttms_pkg::KEY_BITS-1:0] r_key  [ttms_pkg::NODES];

    // winner marks clear at reset, so every node starts as a ghost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= i_wr.node.vld;
        end
    end

    // node payload
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_leaf[i_wr.addr] <= i_wr.node.leaf;
            r_key[i_wr.addr]  <= i_wr.node.key;
        end
    end

    // sibling read
    always_comb begin
        o_rd_node.vld  = r_vld[i_rd_addr];
        o_rd_node.leaf = r_leaf[i_rd_addr];
        o_rd_node.key  = r_key[i_rd_addr];
    end

    // root is node one
    always_comb begin
        o_root.vld  = r_vld[1];
        o_root.leaf = r_leaf[1];
        o_root.key  = r_key[1];
    end

endmodule

`default_nettype wire

### rtl/ttms_match.sv
// one tournament match: ghost loses, smaller key wins, left side wins ties
`default_nettype none

module ttms_match (
    input  wire ttms_pkg::t_node  i_cur,
    input  wire ttms_pkg::t_node  i_sib,
    input  wire logic             i_cur_right,
    output ttms_pkg::t_node       o_win
);

    ttms_pkg::t_node w_left;
    ttms_pkg::t_node w_right;

    // place the climbing node and its sibling on their sides
    always_comb begin
        w_left  = i_cur_right ? i_sib : i_cur;
        w_right = i_cur_right ? i_cur : i_sib;
    end

    // play the match
    always_comb begin
        if (!w_left.vld && !w_right.vld) begin
            o_win = w_left;
        end else if (!w_left.vld) begin
            o_win = w_right;
        end else if (!w_right.vld) begin
            o_win = w_left;
        end else if (w_left.key <= w_right.key) begin
            o_win = w_left;
        end else begin
            o_win = w_right;
        end
    end

endmodule

`default_nettype wire

### rtl/tournament_tree_merge_selector_core.sv
// winner tree selector for a k-way merge: sequencer, node store and match unit
//
//   channel | dir | beat contents                                    | handshake
//   i_req   | in  | req_type, leaf_index, key, refill_valid          | valid/ready
//   o_res   | out | winner_valid, winner_leaf, winner_key, more_pending | valid/ready
//
// an item first reads the root and writes the leaf, then plays one match per tree level
// on the shared match unit
// a pop on an empty tree or an insert beyond the leaf range skips the climb and goes
// from the accept straight to the state that posts the result
// i_req.ready is high only while the sequencer is idle; a held result in o_res does
// not block a new request, only the end of the following one
// synchronous active-low reset marks every node as a ghost at once
`default_nettype none

module tournament_tree_merge_selector_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttms_req_if.sink    i_req,
    ttms_res_if.source  o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLIMB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                               winner_valid;
        logic [ttms_pkg::IDX_BITS-1:0]      winner_leaf;
        logic [ttms_pkg::FKEY_BITS-1:0]     winner_key;
        logic                               more_pending;
    } t_res;

    t_state                         r_state, n_state;
    logic [ttms_pkg::NODE_W-1:0]    r_node, n_node;
    ttms_pkg::t_node                r_cur, n_cur;
    ttms_pkg::t_node                r_win, n_win;
    logic                           r_pop, n_pop;
    logic                           r_out_vld, n_out_vld;
    t_res                           r_res, n_res;

    ttms_pkg::t_node_wr             w_wr;
    ttms_pkg::t_node                w_sib;
    ttms_pkg::t_node                w_root;
    ttms_pkg::t_node                w_par;
    ttms_pkg::t_node                w_leaf_node;
    logic [ttms_pkg::LEAF_W-1:0]    w_target;
    logic [ttms_pkg::NODE_W-1:0]    w_parent;
    logic                           w_accept;
    logic                           w_slot_free;
    logic                           w_in_range;

    // format a result beat; ghost fields read as zero
    function automatic t_res make_res(input logic pop, input ttms_pkg::t_node win,
                                      input ttms_pkg::t_node root);
        t_res            res;
        ttms_pkg::t_node rep;
        rep = pop ? win : root;
        res.winner_valid = rep.vld;
        res.winner_leaf  = rep.vld ? ttms_pkg::IDX_BITS'(rep.leaf) : '0;
        res.winner_key   = rep.vld ? ttms_pkg::FKEY_BITS'(rep.key)
                                   : ttms_pkg::FKEY_BITS'(ttms_pkg::NO_WINNER_KEY);
        res.more_pending = root.vld;
        return res;
    endfunction

    ttms_node_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_node ^ ttms_pkg::NODE_W'(1)),
        .i_wr      (w_wr),
        .o_rd_node (w_sib),
        .o_root    (w_root)
    );

    ttms_match u_match (
        .i_cur       (r_cur),
        .i_sib       (w_sib),
        .i_cur_right (r_node[0]),
        .o_win       (w_par)
    );

    // handshake
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_slot_free  = !r_out_vld || o_res.ready;
    assign w_in_range   = (int'(i_req.leaf_index) < ttms_pkg::LEAVES);
    assign w_parent     = r_node >> 1;

    // leaf written at the start: insert key, or refill / ghost at the popped leaf
    always_comb begin
        w_target = (i_req.req_type == ttms_pkg::REQ_POP) ? w_root.leaf
                                                         : ttms_pkg::LEAF_W'(i_req.leaf_index);
        w_leaf_node.vld  = (i_req.req_type == ttms_pkg::REQ_POP) ? i_req.refill_valid : 1'b1;
        w_leaf_node.leaf = w_target;
        w_leaf_node.key  = ttms_pkg::KEY_BITS'(i_req.key);
    end

    // sequencer next state and node writes
    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_cur     = r_cur;
        n_win     = r_win;
        n_pop     = r_pop;
        n_out_vld = r_out_vld && !o_res.ready;
        n_res     = r_res;
        w_wr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pop = (i_req.req_type == ttms_pkg::REQ_POP);
                    n_win = w_root;
                    if ((i_req.req_type == ttms_pkg::REQ_POP && !w_root.vld) ||
                        (i_req.req_type == ttms_pkg::REQ_INSERT && !w_in_range)) begin
                        // nothing to replay: report the current root
                        n_cur   = w_root;
                        n_state = S_OUT;
                    end else begin
                        w_wr.en   = 1'b1;
                        w_wr.addr = ttms_pkg::NODE_W'(ttms_pkg::SPAN) +
                                    ttms_pkg::NODE_W'(w_target);
                        w_wr.node = w_leaf_node;
                        n_cur     = w_leaf_node;
                        n_node    = w_wr.addr;
                        n_state   = S_CLIMB;
                    end
                end
            end
            S_CLIMB: begin
                // one level per cycle on the shared match unit
                w_wr.en   = 1'b1;
                w_wr.addr = w_parent;
                w_wr.node = w_par;
                n_cur     = w_par;
                n_node    = w_parent;
                if (w_parent == ttms_pkg::NODE_W'(1)) begin
                    if (w_slot_free) begin
                        n_res     = make_res(r_pop, r_win, w_par);
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state   = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_res     = make_res(r_pop, r_win, r_cur);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_node <= n_node;
        r_cur  <= n_cur;
        r_win  <= n_win;
        r_pop  <= n_pop;
        r_res  <= n_res;
    end

    // result beat
    assign o_res.valid        = r_out_vld;
    assign o_res.winner_valid = r_res.winner_valid;
    assign o_res.winner_leaf  = r_res.winner_leaf;
    assign o_res.winner_key   = r_res.winner_key;
    assign o_res.more_pending = r_res.more_pending;

endmodule

`default_nettype wire
